@@ rtl/sobg_pkg.sv @@
// Package: shared constants, types and a helper function for the Sobel gradient stream unit
package sobg_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 10;
    localparam int GRAD_W     = 11;
    localparam int OROW_W     = 12;
    localparam int OCOL_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int LBUF_W     = 2 * PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] MIN_DIM_W       = FW_W'(3);
    localparam logic [FH_W-1:0] MIN_DIM_H       = FH_W'(3);
    localparam logic [FW_W-1:0] MAX_WIDTH_V     = FW_W'(MAX_WIDTH);
    localparam logic [FW_W-1:0] RESET_WIDTH     = FW_W'(640);
    localparam logic [FH_W-1:0] RESET_HEIGHT    = FH_W'(480);

    typedef struct packed {
        logic               valid;
        logic [PIX_W-1:0]   pixel;
        logic [COL_W-1:0]   col;
        logic [FH_W-1:0]    row;
        logic               produce;
        logic               last;
    } stage_t;

    function automatic logic [SUM_W-1:0] weighted(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        weighted = SUM_W'(a) + SUM_W'({b, 1'b0}) + SUM_W'(c);
    endfunction

endpackage

@@ rtl/sobg_line_ram.sv @@
// Dual line buffer memory: one word holds the pixel two rows up and one row up
module sobg_line_ram (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [sobg_pkg::COL_W-1:0]  wr_addr,
    input  logic [sobg_pkg::LBUF_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [sobg_pkg::COL_W-1:0]  rd_addr,
    output logic [sobg_pkg::LBUF_W-1:0] rd_data
);

    logic [sobg_pkg::LBUF_W-1:0] mem [sobg_pkg::MAX_WIDTH];
    logic [sobg_pkg::LBUF_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sobg_ctrl.sv @@
// Frame size registers, raster counters and the input stage register
module sobg_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [sobg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sobg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  logic                           adv,
    input  logic [sobg_pkg::PIX_W-1:0]      pixel,
    output logic [sobg_pkg::COL_W-1:0]      rd_addr,
    output sobg_pkg::stage_t               stage
);

    logic [sobg_pkg::FW_W-1:0]  width_reg,  width_next;
    logic [sobg_pkg::FH_W-1:0]  height_reg, height_next;
    logic [sobg_pkg::COL_W-1:0] col_reg,    col_next;
    logic [sobg_pkg::FH_W-1:0]  row_reg,    row_next;
    sobg_pkg::stage_t           stage_reg,  stage_next;

    logic [sobg_pkg::FW_W-1:0]  fw_raw;
    logic [sobg_pkg::FH_W-1:0]  fh_raw;
    logic                       cfg_hit;
    logic                       col_end;
    logic                       row_end;

    always_comb
    begin
        fw_raw      = cfg_data[sobg_pkg::FW_W-1:0];
        fh_raw      = cfg_data[sobg_pkg::FH_W-1:0];
        width_next  = width_reg;
        height_next = height_reg;
        cfg_hit     = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                sobg_pkg::REG_FRAME_WIDTH:
                begin
                    cfg_hit = 1'b1;
                    if (fw_raw < sobg_pkg::MIN_DIM_W)
                        width_next = sobg_pkg::MIN_DIM_W;
                    else if (fw_raw > sobg_pkg::MAX_WIDTH_V)
                        width_next = sobg_pkg::MAX_WIDTH_V;
                    else
                        width_next = fw_raw;
                end
                sobg_pkg::REG_FRAME_HEIGHT:
                begin
                    cfg_hit = 1'b1;
                    if (fh_raw < sobg_pkg::MIN_DIM_H)
                        height_next = sobg_pkg::MIN_DIM_H;
                    else
                        height_next = fh_raw;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        col_end  = ((sobg_pkg::FW_W + 1)'(col_reg) + 1'b1) >= (sobg_pkg::FW_W + 1)'(width_reg);
        row_end  = ((sobg_pkg::FH_W + 1)'(row_reg) + 1'b1) >= (sobg_pkg::FH_W + 1)'(height_reg);
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid   = 1'b1;
            stage_next.pixel   = pixel;
            stage_next.col     = col_reg;
            stage_next.row     = row_reg;
            stage_next.produce = (row_reg >= sobg_pkg::FH_W'(2)) &&
                                 (col_reg >= sobg_pkg::COL_W'(2));
            stage_next.last    = col_end && row_end;
        end
        else if (adv)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sobg_pkg::RESET_WIDTH;
            height_reg <= sobg_pkg::RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
            stage_reg  <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            stage_reg  <= stage_next;
        end
    end

    assign rd_addr = col_reg;
    assign stage   = stage_reg;

endmodule

@@ rtl/sobg_kernel.sv @@
// 3x3 window, Sobel gradient arithmetic and the result register
module sobg_kernel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sobg_pkg::stage_t                  stage,
    input  logic [sobg_pkg::LBUF_W-1:0]        rd_data,
    input  logic                              out_stall,
    output logic                              adv,
    output logic [sobg_pkg::LBUF_W-1:0]        wr_data,
    output logic                              out_valid,
    output logic signed [sobg_pkg::GRAD_W-1:0] grad_x,
    output logic signed [sobg_pkg::GRAD_W-1:0] grad_y,
    output logic [sobg_pkg::OROW_W-1:0]        out_row,
    output logic [sobg_pkg::OCOL_W-1:0]        out_col,
    output logic                              last_of_frame
);

    logic [sobg_pkg::PIX_W-1:0] win_reg [3][3];
    logic [sobg_pkg::PIX_W-1:0] top_px;
    logic [sobg_pkg::PIX_W-1:0] mid_px;
    logic [sobg_pkg::SUM_W-1:0] sum_right, sum_left, sum_bottom, sum_top;

    logic                              out_valid_reg, out_valid_next;
    logic signed [sobg_pkg::GRAD_W-1:0] grad_x_reg, grad_x_next;
    logic signed [sobg_pkg::GRAD_W-1:0] grad_y_reg, grad_y_next;
    logic [sobg_pkg::OROW_W-1:0]        out_row_reg, out_row_next;
    logic [sobg_pkg::OCOL_W-1:0]        out_col_reg, out_col_next;
    logic                              last_reg, last_next;

    assign top_px  = rd_data[sobg_pkg::LBUF_W-1:sobg_pkg::PIX_W];
    assign mid_px  = rd_data[sobg_pkg::PIX_W-1:0];
    assign wr_data = {mid_px, stage.pixel};

    assign adv = stage.valid && (!stage.produce || !out_valid_reg || !out_stall);

    // window columns after the shift: old col 1, old col 2, new column
    always_comb
    begin
        sum_right  = sobg_pkg::weighted(top_px, mid_px, stage.pixel);
        sum_left   = sobg_pkg::weighted(win_reg[0][1], win_reg[1][1], win_reg[2][1]);
        sum_bottom = sobg_pkg::weighted(win_reg[2][1], win_reg[2][2], stage.pixel);
        sum_top    = sobg_pkg::weighted(win_reg[0][1], win_reg[0][2], top_px);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        grad_x_next    = grad_x_reg;
        grad_y_next    = grad_y_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        last_next      = last_reg;
        if (adv && stage.produce)
        begin
            out_valid_next = 1'b1;
            grad_x_next    = $signed({1'b0, sum_right})  - $signed({1'b0, sum_left});
            grad_y_next    = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
            out_row_next   = sobg_pkg::OROW_W'(stage.row - 1'b1);
            out_col_next   = sobg_pkg::OCOL_W'(stage.col - 1'b1);
            last_next      = stage.last;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= top_px;
                win_reg[1][2] <= mid_px;
                win_reg[2][2] <= stage.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grad_x_reg  <= grad_x_next;
        grad_y_reg  <= grad_y_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign grad_x        = grad_x_reg;
    assign grad_y        = grad_y_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign last_of_frame = last_reg;

endmodule

@@ rtl/sobel_gradient_stream_unit.sv @@
// Top level: streaming 3x3 Sobel gradient unit with line buffers and configuration port
// Path: an accepted pixel is held in the input stage register, then its result is registered for out_valid.
// Throughput: one pixel per cycle unless out_stall holds a pending result; the single-port-per-side line RAM
//   read and write of neighbouring columns set that figure, and no stage loops.
// Reset: rst_n clears counters, window and valid flags; width resets to 640, height to 480.
//   Line RAM contents are not cleared; rows 0 and 1 overwrite them before use.
module sobel_gradient_stream_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sobg_pkg::PIX_W-1:0]         pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sobg_pkg::GRAD_W-1:0] grad_x,
    output logic signed [sobg_pkg::GRAD_W-1:0] grad_y,
    output logic [sobg_pkg::OROW_W-1:0]        out_row,
    output logic [sobg_pkg::OCOL_W-1:0]        out_col,
    output logic                              last_of_frame,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sobg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sobg_pkg::stage_t             stage;
    logic                         accept;
    logic                         adv;
    logic [sobg_pkg::COL_W-1:0]    rd_addr;
    logic [sobg_pkg::LBUF_W-1:0]   rd_data;
    logic [sobg_pkg::LBUF_W-1:0]   wr_data;

    assign in_stall  = stage.valid && !adv;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    sobg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .adv       (adv),
        .pixel     (pixel),
        .rd_addr   (rd_addr),
        .stage     (stage)
    );

    sobg_line_ram u_line_ram (
        .clk     (clk),
        .wr_en   (adv),
        .wr_addr (stage.col),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sobg_kernel u_kernel (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage),
        .rd_data       (rd_data),
        .out_stall     (out_stall),
        .adv           (adv),
        .wr_data       (wr_data),
        .out_valid     (out_valid),
        .grad_x        (grad_x),
        .grad_y        (grad_y),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_frame (last_of_frame)
    );

endmodule

@@ rtl/sobg_checker.sv @@
// Port-level checker for the Sobel gradient stream unit, bound to the top level
module sobg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [sobg_pkg::PIX_W-1:0]         pixel,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [sobg_pkg::GRAD_W-1:0] grad_x,
    input logic signed [sobg_pkg::GRAD_W-1:0] grad_y,
    input logic [sobg_pkg::OROW_W-1:0]        out_row,
    input logic [sobg_pkg::OCOL_W-1:0]        out_col,
    input logic                              last_of_frame,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [sobg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [sobg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // a stalled result item holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(grad_x) && $stable(grad_y) &&
        $stable(out_row) && $stable(out_col) && $stable(last_of_frame))
        else $error("result item changed while stalled");

    // no result names a pixel in row 0 or column 0
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_row != '0 && out_col != '0)
        else $error("result for a border pixel");

    a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> grad_x >= -11'sd1020 && grad_x <= 11'sd1020 &&
                      grad_y >= -11'sd1020 && grad_y <= 11'sd1020)
        else $error("gradient out of range");

    // no result can exist right after leaving reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid ##1 !out_valid)
        else $error("result item right after reset");

endmodule

bind sobel_gradient_stream_unit sobg_checker u_sobg_checker (.*);

@@ tb/sv/sobel_gradient_checker.sv @@
// Checker: predicts Sobel gradient results from accepted pixels and register writes, compares outputs
module sobel_gradient_checker
    import sobg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [PIX_W-1:0]          pixel,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [GRAD_W-1:0]  grad_x,
    input  logic signed [GRAD_W-1:0]  grad_y,
    input  logic [OROW_W-1:0]         out_row,
    input  logic [OCOL_W-1:0]         out_col,
    input  logic                      last_of_frame,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [OROW_W-1:0]        row;
        logic [OCOL_W-1:0]        col;
        logic                     last;
    } gradient_t;

    gradient_t        gradient_q[$];
    logic [PIX_W-1:0] line_above [MAX_WIDTH];
    logic [PIX_W-1:0] line_two_above [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    int               col_pos;
    int               row_pos;

    function automatic int active_width();
        if (width_reg < MIN_DIM_W)
            return int'(MIN_DIM_W);
        if (int'(width_reg) > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg < MIN_DIM_H)
            return int'(MIN_DIM_H);
        return int'(height_reg);
    endfunction

    function automatic int tap_sum(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                   logic [PIX_W-1:0] c);
        return int'(a) + 2 * int'(b) + int'(c);
    endfunction

    task automatic clear_model();
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        col_pos    = 0;
        row_pos    = 0;
        fail_count = 0;
        gradient_q.delete();
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win[i][j] = '0;
            end
        end
    endtask

    task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_reg = FW_W'(data);
                col_pos   = 0;
                row_pos   = 0;
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg = FH_W'(data);
                col_pos    = 0;
                row_pos    = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_pixel(logic [PIX_W-1:0] px);
        int               w;
        int               h;
        int               c;
        int               r;
        int               gx;
        int               gy;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] above2;
        gradient_t        res;
        w = active_width();
        h = active_height();
        c = col_pos;
        r = row_pos;
        above2 = line_two_above[c];
        above  = line_above[c];
        line_two_above[c] = above;
        line_above[c]     = px;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = above2;
        win[1][2] = above;
        win[2][2] = px;
        if (r >= 2 && c >= 2)
        begin
            gx = tap_sum(win[0][2], win[1][2], win[2][2])
               - tap_sum(win[0][0], win[1][0], win[2][0]);
            gy = tap_sum(win[2][0], win[2][1], win[2][2])
               - tap_sum(win[0][0], win[0][1], win[0][2]);
            res.gx   = GRAD_W'(gx);
            res.gy   = GRAD_W'(gy);
            res.row  = OROW_W'(r - 1);
            res.col  = OCOL_W'(c - 1);
            res.last = (r == h - 1) && (c == w - 1);
            gradient_q.push_back(res);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_result();
        gradient_t want;
        if (gradient_q.size() == 0)
        begin
            $error("unexpected result: row %0d col %0d", out_row, out_col);
            fail_count++;
            return;
        end
        want = gradient_q.pop_front();
        if (grad_x !== want.gx)
        begin
            $error("grad_x: expected %0d, got %0d", want.gx, grad_x);
            fail_count++;
        end
        if (grad_y !== want.gy)
        begin
            $error("grad_y: expected %0d, got %0d", want.gy, grad_y);
            fail_count++;
        end
        if (out_row !== want.row)
        begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            fail_count++;
        end
        if (out_col !== want.col)
        begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            fail_count++;
        end
        if (last_of_frame !== want.last)
        begin
            $error("last_of_frame: expected %0d, got %0d", want.last, last_of_frame);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                predict_pixel(pixel);
        end
        pending = gradient_q.size();
    end

endmodule

@@ tb/sv/sobel_gradient_stream_unit_test.sv @@
// Testbench top: drives pixels, register writes and output stalls; reports the verdict
module sobel_gradient_stream_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sobg_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 100;
    localparam int DEFAULT_LEAD    = 1290;
    localparam int WIDE_ITEMS      = 16;
    localparam int TALL_ROWS       = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum {BAR_LEFT, BAR_RIGHT, BAR_TOP, BAR_BOTTOM} bar_t;
    typedef enum {PIX_RANDOM, PIX_BINARY} pix_mode_t;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [PIX_W-1:0]          pixel         = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic signed [GRAD_W-1:0]  grad_x;
    logic signed [GRAD_W-1:0]  grad_y;
    logic [OROW_W-1:0]         out_row;
    logic [OCOL_W-1:0]         out_col;
    logic                      last_of_frame;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;
    int                        fail_count;
    int                        pending;

    bit                        hold_off_req  = 1'b0;
    int                        burst_left    = 0;

    sobel_gradient_stream_unit i_dut (.*);

    sobel_gradient_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic push_pixel(logic [PIX_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 64);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        pixel    <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_pixels(int count, pix_mode_t mode);
        repeat (count)
        begin
            if (mode == PIX_BINARY)
                push_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
            else
                push_pixel(PIX_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_bar_frame(bar_t bar);
        logic hit;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                case (bar)
                    BAR_LEFT:   hit = (c == 0);
                    BAR_RIGHT:  hit = (c == 2);
                    BAR_TOP:    hit = (r == 0);
                    default:    hit = (r == 2);
                endcase
                push_pixel(hit ? 8'hFF : 8'h00);
            end
        end
    endtask

    // block must be idle: all results out, then time for items that give none
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        stall_mode_t mode;
        int          span;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !hold_done)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_off_req && !hold_done)
                    break;
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    default:      out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sobel_gradient_stream_unit test failed");
        $finish;
    end

    initial
    begin
        int        random_items;
        int        w;
        int        h;
        int        frame_size;
        int        split;
        int        tail;
        pix_mode_t mode;
        random_items = 0;
        @(posedge rst_n);

        // reset size 640x480, run into row 2
        send_pixels(DEFAULT_LEAD, PIX_RANDOM);

        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        send_bar_frame(BAR_LEFT);
        send_bar_frame(BAR_RIGHT);
        send_bar_frame(BAR_TOP);
        send_bar_frame(BAR_BOTTOM);

        // spare indexes must not restart the frame
        send_pixels(4, PIX_RANDOM);
        write_reg(REG_SPARE_A, 12'hFFF);
        write_reg(REG_SPARE_B, 12'h000);
        send_pixels(5, PIX_RANDOM);

        // mid-frame restart
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(4));
        send_pixels(6, PIX_RANDOM);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        send_pixels(9, PIX_BINARY);

        // widest clamped frame, lowest height
        write_reg(REG_FRAME_WIDTH, 12'hFFF);
        write_reg(REG_FRAME_HEIGHT, 12'h000);
        send_pixels(WIDE_ITEMS, PIX_RANDOM);

        // narrowest clamped frame, tallest height; receiver holds off here
        write_reg(REG_FRAME_WIDTH, 12'h001);
        write_reg(REG_FRAME_HEIGHT, 12'hFFF);
        hold_off_req = 1'b1;
        send_pixels(3 * TALL_ROWS, PIX_RANDOM);

        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(13, 24);
                default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_FRAME_WIDTH, {1'($urandom_range(0, 1)), FW_W'(w)});
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            end
            else
            begin
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
                write_reg(REG_FRAME_WIDTH, {1'($urandom_range(0, 1)), FW_W'(w)});
            end
            frame_size = ((w < 3) ? 3 : w) * ((h < 3) ? 3 : h);
            mode = ($urandom_range(0, 3) == 0) ? PIX_BINARY : PIX_RANDOM;
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    split = $urandom_range(1, frame_size - 1);
                    send_pixels(split, mode);
                    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                              CFG_DATA_W'($urandom));
                    send_pixels(frame_size - split, mode);
                end
                else
                begin
                    send_pixels(frame_size, mode);
                end
                random_items += frame_size;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                tail = $urandom_range(1, frame_size - 1);
                send_pixels(tail, mode);
                random_items += tail;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("sobel_gradient_stream_unit test passed");
        else
            $display("sobel_gradient_stream_unit test failed");
        $finish;
    end

endmodule
